/* rtl/core/wino_pkg.sv */
// Package for the Winograd F(2x2,3x3) tile transform unit.
// Request and result payload structs, value types and mode codes; no dependencies.
`default_nettype none

package wino_pkg;

    localparam int LANE_W  = 16;
    localparam int VALUE_W = 20;

    localparam logic [1:0] MODE_INPUT  = 2'd0;
    localparam logic [1:0] MODE_KERNEL = 2'd1;
    localparam logic [1:0] MODE_OUTPUT = 2'd2;
    localparam logic [1:0] MODE_DROP   = 2'd3;

    localparam logic [1:0] LAST_ROW_FULL = 2'd3;
    localparam logic [1:0] LAST_ROW_OUT  = 2'd1;

    typedef logic signed [VALUE_W-1:0] val_t;
    typedef val_t [3:0] vrow_t;
    typedef vrow_t [3:0] vtile_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] row0;
        logic [63:0] row1;
        logic [63:0] row2;
        logic [63:0] row3;
    } req_t;

    typedef struct packed {
        logic [1:0] row_index;
        val_t       value0;
        val_t       value1;
        val_t       value2;
        val_t       value3;
        logic       last;
    } rsp_t;

endpackage

`default_nettype wire

/* rtl/core/winograd_f2x2_3x3_transform_unit.sv */
// Winograd F(2x2,3x3) tile transform unit, top level.
// Depends on wino_pkg (payload structs, value types, mode codes).
//
// Usage:
//   A request on the tile channel carries a mode and four packed 4x16-bit rows.
//   Mode 0 gives B^T d B (four result rows), mode 1 gives 4 * G g G^T of the 3x3
//   kernel in rows 0..2 (four result rows), mode 2 gives A^T m A (two result
//   rows, columns 2 and 3 zero). Mode 3 requests are taken and dropped.
//   Results leave on the row channel one row per cycle while row_stall is low, last set on the final one.
//   A request passes the lane sign extension, column pass and row pass stages,
//   then the row serializer, before its first row is valid.
//   The single-row output port of the serializer limits the request rate: it
//   drains four rows per tile in modes 0 and 1 and two rows in mode 2.
//   Requests keep entering the pipeline while the serializer drains a tile.
//   Reset clears all valid bits and the row counter; no clearing pass.
//   When row_stall is high the current row holds and the stages fill up, then
//   tile_stall rises; nothing is lost or repeated.
`default_nettype none

module winograd_f2x2_3x3_transform_unit
    import wino_pkg::*;
#(
    parameter int DATA_WIDTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic tile_valid,
    output logic      tile_stall,
    input  wire req_t tile,
    output logic      row_valid,
    input  wire logic row_stall,
    output rsp_t      row
);

    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg, ser_valid_reg;
    logic [1:0] s1_mode_reg, s2_mode_reg, s3_mode_reg, ser_mode_reg;
    vtile_t     s1_d_reg, s2_t_reg, s3_r_reg, ser_tile_reg;
    vtile_t     s1_d_next, s2_t_next, s3_r_next;
    logic [1:0] idx_reg, idx_next;

    logic s1_rdy, s2_rdy, s3_rdy, ser_rdy;
    logic [1:0] last_row;
    logic       row_done;

    logic [3:0][63:0] in_rows;
    assign in_rows = {tile.row3, tile.row2, tile.row1, tile.row0};

    // handshake chain
    assign last_row   = (ser_mode_reg == MODE_OUTPUT) ? LAST_ROW_OUT : LAST_ROW_FULL;
    assign row_done   = ser_valid_reg && !row_stall && (idx_reg == last_row);
    assign ser_rdy    = !ser_valid_reg || row_done;
    assign s3_rdy     = !s3_valid_reg || ser_rdy;
    assign s2_rdy     = !s2_valid_reg || s3_rdy;
    assign s1_rdy     = !s1_valid_reg || s2_rdy;
    assign tile_stall = !s1_rdy;

    // stage 1: lane sign extension
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                s1_d_next[i][j] = val_t'({{(VALUE_W-DATA_WIDTH){in_rows[i][LANE_W*j+DATA_WIDTH-1]}},
                                          in_rows[i][LANE_W*j +: DATA_WIDTH]});
            end
        end
    end

    // stage 2: column pass
    always_comb
    begin
        s2_t_next = '0;
        for (int j = 0; j < 4; j++)
        begin
            case (s1_mode_reg)
                MODE_INPUT:
                begin
                    s2_t_next[0][j] = s1_d_reg[0][j] - s1_d_reg[2][j];
                    s2_t_next[1][j] = s1_d_reg[1][j] + s1_d_reg[2][j];
                    s2_t_next[2][j] = s1_d_reg[2][j] - s1_d_reg[1][j];
                    s2_t_next[3][j] = s1_d_reg[1][j] - s1_d_reg[3][j];
                end
                MODE_KERNEL:
                begin
                    if (j < 3)
                    begin
                        s2_t_next[0][j] = s1_d_reg[0][j] <<< 1;
                        s2_t_next[1][j] = s1_d_reg[0][j] + s1_d_reg[1][j] + s1_d_reg[2][j];
                        s2_t_next[2][j] = s1_d_reg[0][j] - s1_d_reg[1][j] + s1_d_reg[2][j];
                        s2_t_next[3][j] = s1_d_reg[2][j] <<< 1;
                    end
                end
                MODE_OUTPUT:
                begin
                    s2_t_next[0][j] = s1_d_reg[0][j] + s1_d_reg[1][j] + s1_d_reg[2][j];
                    s2_t_next[1][j] = s1_d_reg[1][j] - s1_d_reg[2][j] - s1_d_reg[3][j];
                end
                default:
                begin
                    s2_t_next[0][j] = '0;
                end
            endcase
        end
    end

    // stage 3: row pass
    always_comb
    begin
        s3_r_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            case (s2_mode_reg)
                MODE_INPUT:
                begin
                    s3_r_next[i][0] = s2_t_reg[i][0] - s2_t_reg[i][2];
                    s3_r_next[i][1] = s2_t_reg[i][1] + s2_t_reg[i][2];
                    s3_r_next[i][2] = s2_t_reg[i][2] - s2_t_reg[i][1];
                    s3_r_next[i][3] = s2_t_reg[i][1] - s2_t_reg[i][3];
                end
                MODE_KERNEL:
                begin
                    s3_r_next[i][0] = s2_t_reg[i][0] <<< 1;
                    s3_r_next[i][1] = s2_t_reg[i][0] + s2_t_reg[i][1] + s2_t_reg[i][2];
                    s3_r_next[i][2] = s2_t_reg[i][0] - s2_t_reg[i][1] + s2_t_reg[i][2];
                    s3_r_next[i][3] = s2_t_reg[i][2] <<< 1;
                end
                MODE_OUTPUT:
                begin
                    if (i < 2)
                    begin
                        s3_r_next[i][0] = s2_t_reg[i][0] + s2_t_reg[i][1] + s2_t_reg[i][2];
                        s3_r_next[i][1] = s2_t_reg[i][1] - s2_t_reg[i][2] - s2_t_reg[i][3];
                    end
                end
                default:
                begin
                    s3_r_next[i][0] = '0;
                end
            endcase
        end
    end

    // serializer row counter
    always_comb
    begin
        idx_next = idx_reg;
        if (ser_rdy)
        begin
            idx_next = '0;
        end
        else if (!row_stall)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            ser_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (s1_rdy)
            begin
                s1_valid_reg <= tile_valid && (tile.mode != MODE_DROP);
            end
            if (s2_rdy)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_rdy)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (ser_rdy)
            begin
                ser_valid_reg <= s3_valid_reg;
            end
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy)
        begin
            s1_mode_reg <= tile.mode;
            s1_d_reg    <= s1_d_next;
        end
        if (s2_rdy)
        begin
            s2_mode_reg <= s1_mode_reg;
            s2_t_reg    <= s2_t_next;
        end
        if (s3_rdy)
        begin
            s3_mode_reg <= s2_mode_reg;
            s3_r_reg    <= s3_r_next;
        end
        if (ser_rdy)
        begin
            ser_mode_reg <= s3_mode_reg;
            ser_tile_reg <= s3_r_reg;
        end
    end

    assign row_valid     = ser_valid_reg;
    assign row.row_index = idx_reg;
    assign row.value0    = ser_tile_reg[idx_reg][0];
    assign row.value1    = ser_tile_reg[idx_reg][1];
    assign row.value2    = ser_tile_reg[idx_reg][2];
    assign row.value3    = ser_tile_reg[idx_reg][3];
    assign row.last      = (idx_reg == last_row);

endmodule

`default_nettype wire

/* dv/tb_winograd_f2x2_3x3_transform_unit.sv */
`timescale 1ns / 1ps
// Testbench for winograd_f2x2_3x3_transform_unit: row scoreboard class with a tile
// transform predictor, request/row drivers with bursty traffic and patterned stalls.
// Depends on wino_pkg and the RTL top level only.

import wino_pkg::*;

class tile_row_scoreboard;
    rsp_t expected_rows[$];
    int   errors;

    // One pass of the selected 1-D transform over four values.
    function void transform_1d(input logic [1:0] mode, input int v[4], output int o[4]);
        o = '{0, 0, 0, 0};
        case (mode)
            MODE_INPUT:
            begin
                o[0] = v[0] - v[2];
                o[1] = v[1] + v[2];
                o[2] = v[2] - v[1];
                o[3] = v[1] - v[3];
            end
            MODE_KERNEL:
            begin
                o[0] = 2 * v[0];
                o[1] = v[0] + v[1] + v[2];
                o[2] = v[0] - v[1] + v[2];
                o[3] = 2 * v[2];
            end
            MODE_OUTPUT:
            begin
                o[0] = v[0] + v[1] + v[2];
                o[1] = v[1] - v[2] - v[3];
            end
            default:
            begin
            end
        endcase
    endfunction

    function void note_tile(req_t t);
        logic [63:0]        rows [4];
        logic signed [15:0] lane;
        int                 d    [4][4];
        int                 tr   [4][4];
        int                 res  [4][4];
        int                 col  [4];
        int                 o    [4];
        int                 nrows;
        rsp_t               r;
        if (t.mode != MODE_INPUT && t.mode != MODE_KERNEL && t.mode != MODE_OUTPUT)
            return;
        rows = '{t.row0, t.row1, t.row2, t.row3};
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
            begin
                lane = rows[i][16*j +: 16];
                d[i][j] = lane;
            end
        for (int j = 0; j < 4; j++)
        begin
            for (int i = 0; i < 4; i++)
                col[i] = d[i][j];
            transform_1d(t.mode, col, o);
            for (int i = 0; i < 4; i++)
                tr[i][j] = o[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
                col[j] = tr[i][j];
            transform_1d(t.mode, col, o);
            for (int j = 0; j < 4; j++)
                res[i][j] = o[j];
        end
        nrows = (t.mode == MODE_OUTPUT) ? 2 : 4;
        for (int i = 0; i < nrows; i++)
        begin
            r.row_index = 2'(i);
            r.value0    = val_t'(res[i][0]);
            r.value1    = val_t'(res[i][1]);
            r.value2    = val_t'(res[i][2]);
            r.value3    = val_t'(res[i][3]);
            r.last      = (i == nrows - 1);
            expected_rows.push_back(r);
        end
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task compare_field(string name, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
        if (got !== want)
            report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_row(rsp_t got);
        rsp_t want;
        if (expected_rows.size() == 0)
        begin
            report($sformatf("unexpected row, index %0d", got.row_index));
            return;
        end
        want = expected_rows.pop_front();
        compare_field("row_index", VALUE_W'(got.row_index), VALUE_W'(want.row_index));
        compare_field("value0", got.value0, want.value0);
        compare_field("value1", got.value1, want.value1);
        compare_field("value2", got.value2, want.value2);
        compare_field("value3", got.value3, want.value3);
        compare_field("last", VALUE_W'(got.last), VALUE_W'(want.last));
    endtask
endclass

module tb_winograd_f2x2_3x3_transform_unit;

    localparam int          CYCLE_LIMIT = 200000;
    localparam logic [63:0] ALL_MAX     = {4{16'h7FFF}};
    localparam logic [63:0] ALL_MIN     = {4{16'h8000}};
    localparam logic [63:0] ALL_ONES    = {4{16'hFFFF}};
    localparam logic [63:0] ALL_UNIT    = {4{16'h0001}};
    localparam logic [63:0] CHECK_A     = {2{16'h8000, 16'h7FFF}};
    localparam logic [63:0] CHECK_B     = {2{16'h7FFF, 16'h8000}};

    logic clk;
    logic rst_n      = 1'b0;
    logic tile_valid = 1'b0;
    logic tile_stall;
    req_t tile       = '0;
    logic row_valid;
    logic row_stall  = 1'b0;
    rsp_t row;

    tile_row_scoreboard sb = new();
    int cycles;
    int stall_left;
    int stall_style;
    logic stall_toggle = 1'b0;

    winograd_f2x2_3x3_transform_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tile_valid (tile_valid),
        .tile_stall (tile_stall),
        .tile       (tile),
        .row_valid  (row_valid),
        .row_stall  (row_stall),
        .row        (row)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: the stall style changes after each randomly drawn run
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(10, 80);
        end
        stall_left--;
        stall_toggle = ~stall_toggle;
        case (stall_style)
            0: row_stall <= 1'b0;
            1: row_stall <= ($urandom_range(0, 99) < 30);
            2: row_stall <= ($urandom_range(0, 99) < 75);
            default: row_stall <= stall_toggle;
        endcase
    end

    always @(posedge clk)
        if (rst_n && row_valid && !row_stall)
            sb.check_row(row);

    function automatic req_t mk_tile(logic [1:0] mode, logic [63:0] r0, logic [63:0] r1,
                                     logic [63:0] r2, logic [63:0] r3);
        req_t t;
        t.mode = mode;
        t.row0 = r0;
        t.row1 = r1;
        t.row2 = r2;
        t.row3 = r3;
        return t;
    endfunction

    function automatic logic [15:0] pick_lane();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] pick_row();
        if ($urandom_range(0, 3) == 0)
            return {$urandom, $urandom};
        return {pick_lane(), pick_lane(), pick_lane(), pick_lane()};
    endfunction

    function automatic logic [1:0] pick_mode();
        int k;
        k = $urandom_range(0, 11);
        if (k == 0)
            return MODE_DROP;
        if (k <= 4)
            return MODE_INPUT;
        if (k <= 8)
            return MODE_KERNEL;
        return MODE_OUTPUT;
    endfunction

    task send_tile(req_t t);
        @(negedge clk);
        tile       <= t;
        tile_valid <= 1'b1;
        do
            @(posedge clk);
        while (tile_stall);
        sb.note_tile(t);
    endtask

    task idle_sender(int n);
        repeat (n)
        begin
            @(negedge clk);
            tile_valid <= 1'b0;
        end
    endtask

    task wait_drained();
        while (sb.expected_rows.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        req_t t;
        int   sent;
        int   burst;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // extremes per mode, back to back
        send_tile(mk_tile(MODE_INPUT, '0, '0, '0, '0));
        send_tile(mk_tile(MODE_KERNEL, '0, '0, '0, '0));
        send_tile(mk_tile(MODE_OUTPUT, '0, '0, '0, '0));
        send_tile(mk_tile(MODE_INPUT, ALL_MAX, ALL_MAX, ALL_MAX, ALL_MAX));
        send_tile(mk_tile(MODE_KERNEL, ALL_MAX, ALL_MAX, ALL_MAX, ALL_MAX));
        send_tile(mk_tile(MODE_OUTPUT, ALL_MAX, ALL_MAX, ALL_MAX, ALL_MAX));
        send_tile(mk_tile(MODE_INPUT, ALL_MIN, ALL_MIN, ALL_MIN, ALL_MIN));
        send_tile(mk_tile(MODE_KERNEL, ALL_MIN, ALL_MIN, ALL_MIN, ALL_MIN));
        send_tile(mk_tile(MODE_OUTPUT, ALL_MIN, ALL_MIN, ALL_MIN, ALL_MIN));
        send_tile(mk_tile(MODE_INPUT, CHECK_A, CHECK_B, CHECK_A, CHECK_B));
        send_tile(mk_tile(MODE_KERNEL, CHECK_A, CHECK_B, CHECK_A, CHECK_B));
        send_tile(mk_tile(MODE_OUTPUT, CHECK_A, CHECK_B, CHECK_A, CHECK_B));
        send_tile(mk_tile(MODE_OUTPUT, ALL_MAX, ALL_MIN, ALL_MIN, ALL_MAX));
        send_tile(mk_tile(MODE_INPUT, ALL_ONES, ALL_UNIT, ALL_ONES, ALL_UNIT));
        send_tile(mk_tile(MODE_OUTPUT, ALL_UNIT, ALL_ONES, ALL_UNIT, ALL_ONES));
        // kernel: lane 3 and row 3 carry junk that must not matter
        send_tile(mk_tile(MODE_KERNEL, {16'h8000, {3{16'h0001}}}, {16'h7FFF, {3{16'hFFFF}}},
                          {16'h1234, {3{16'h0001}}}, ALL_MIN));
        send_tile(mk_tile(MODE_DROP, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
        send_tile(mk_tile(MODE_INPUT, pick_row(), pick_row(), pick_row(), pick_row()));
        send_tile(mk_tile(MODE_DROP, '0, '0, '0, '0));
        send_tile(mk_tile(MODE_KERNEL, pick_row(), pick_row(), pick_row(), pick_row()));
        idle_sender(1);
        wait_drained();

        sent  = 0;
        burst = 0;
        while (sent < 250)
        begin
            if (burst == 0)
            begin
                idle_sender($urandom_range(1, 8));
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 10);
            end
            t = mk_tile(pick_mode(), pick_row(), pick_row(), pick_row(), pick_row());
            send_tile(t);
            burst--;
            if (t.mode != MODE_DROP)
            begin
                sent++;
                if (sent == 125)
                begin
                    idle_sender(1);
                    wait_drained();
                end
            end
        end

        idle_sender(1);
        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
rtl/core/wino_pkg.sv
rtl/core/winograd_f2x2_3x3_transform_unit.sv
dv/tb_winograd_f2x2_3x3_transform_unit.sv
